// ----- rtl/categorical_bayes_fusion_top_defines.svh -----
// Assertion macros used by the top-level RTL file.
`ifndef CATEGORICAL_BAYES_FUSION_TOP_DEFINES_SVH
`define CATEGORICAL_BAYES_FUSION_TOP_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define CBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked on every rising edge outside reset.
`define CBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/cbf_pkg.sv -----
package cbf_pkg;
  localparam int SCORE_W = 24;
  localparam int LABEL_W = 4;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int DEF_NUM_LABELS = 16;
  localparam int DEF_FRAC_BITS = 16;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

  localparam logic [ACTION_W-1:0] ACT_SET = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SET_UNK = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_OBS = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_OBS_END = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_MAX = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_NORM = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LABEL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL = 2'd2;

  // Datapath operations issued by the controller.
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LATCH = 4'd1;   // capture input, do the actions that need no slot sweep
  localparam logic [3:0] OP_SCAN = 4'd2;    // per-slot step of maximum / count / total
  localparam logic [3:0] OP_MUL = 4'd3;     // per-slot update product
  localparam logic [3:0] OP_MUL_UNK = 4'd4; // unknown mass product
  localparam logic [3:0] OP_DIV_START = 4'd5;
  localparam logic [3:0] OP_DIV_STEP = 4'd6;
  localparam logic [3:0] OP_DIV_WB = 4'd7;
  localparam logic [3:0] OP_CLR_OBS = 4'd8;
  localparam logic [3:0] OP_SHARE_START = 4'd9;

  typedef struct packed {
    logic [3:0] op;
    logic       first;      // first slot of a sweep
    logic       div_unk;    // divide targets unknown mass
    logic       set_status_bad;
    logic       set_status_zero;
  } cbf_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                obs_bad;
    logic                obs_any;
    logic                total_zero;
    logic                slot_valid;
    logic                div_done;
  } cbf_stat_t;
endpackage

// ----- rtl/cbf_ctrl.sv -----
module cbf_ctrl
  import cbf_pkg::*;
#(
  parameter int NUM_LABELS = DEF_NUM_LABELS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_free,
  output logic      busy,
  output logic      result_load,
  output logic [$clog2(NUM_LABELS)-1:0] slot,
  output cbf_cmd_t  cmd,
  input  cbf_stat_t stat
);
  localparam int SW = $clog2(NUM_LABELS);
  localparam logic [SW-1:0] LAST = SW'(NUM_LABELS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_SHARE = 4'd3;
  localparam logic [3:0] S_MUL = 4'd4;
  localparam logic [3:0] S_MUL_UNK = 4'd5;
  localparam logic [3:0] S_TOTAL = 4'd6;
  localparam logic [3:0] S_DIV_START = 4'd7;
  localparam logic [3:0] S_DIV = 4'd8;
  localparam logic [3:0] S_DIV_WB = 4'd9;
  localparam logic [3:0] S_CLR = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0] state, state_next;
  logic [SW-1:0] slot_next;
  logic norm_unk, norm_unk_next;
  logic prod_done, prod_done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot <= '0;
      norm_unk <= 1'b0;
      prod_done <= 1'b0;
    end else begin
      state <= state_next;
      slot <= slot_next;
      norm_unk <= norm_unk_next;
      prod_done <= prod_done_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    slot_next = slot;
    norm_unk_next = norm_unk;
    prod_done_next = prod_done;
    cmd = '0;
    result_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op = OP_LATCH;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        slot_next = '0;
        prod_done_next = 1'b0;
        if (stat.action == ACT_MAX || stat.action == ACT_NORM
            || stat.action == ACT_OBS_END) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        cmd.first = (slot == '0);
        if (slot == LAST) begin
          slot_next = '0;
          if (stat.action == ACT_OBS_END) begin
            if (prod_done) begin
              // Second scan after the products: normalize.
              state_next = S_TOTAL;
            end else if (!stat.obs_any) begin
              state_next = S_CLR;
            end else if (stat.obs_bad) begin
              cmd.set_status_bad = 1'b1;
              state_next = S_CLR;
            end else begin
              state_next = S_SHARE;
            end
          end else if (stat.action == ACT_NORM) begin
            state_next = S_TOTAL;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      S_SHARE: begin
        cmd.op = OP_SHARE_START;
        state_next = S_DIV;
        norm_unk_next = 1'b0;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        if (slot == LAST) begin
          slot_next = '0;
          state_next = S_MUL_UNK;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      S_MUL_UNK: begin
        cmd.op = OP_MUL_UNK;
        prod_done_next = 1'b1;
        state_next = S_SCAN;
      end
      S_TOTAL: begin
        if (stat.total_zero) begin
          cmd.set_status_zero = 1'b1;
          state_next = S_CLR;
        end else begin
          norm_unk_next = 1'b1;
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        if (norm_unk || stat.slot_valid) begin
          cmd.op = OP_DIV_START;
          cmd.div_unk = norm_unk;
          state_next = S_DIV;
        end else if (slot == LAST) begin
          state_next = S_CLR;
        end else begin
          slot_next = slot + 1'b1;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (stat.div_done) state_next = S_DIV_WB;
      end
      S_DIV_WB: begin
        cmd.op = OP_DIV_WB;
        cmd.div_unk = norm_unk;
        if (stat.action == ACT_OBS_END && !stat.obs_any) begin
          // share division finished, now the products
          state_next = S_MUL;
          slot_next = '0;
        end else if (norm_unk) begin
          norm_unk_next = 1'b0;
          slot_next = '0;
          state_next = S_DIV_START;
        end else if (slot == LAST) begin
          state_next = S_CLR;
        end else begin
          slot_next = slot + 1'b1;
          state_next = S_DIV_START;
        end
      end
      S_CLR: begin
        if (stat.action == ACT_OBS_END) cmd.op = OP_CLR_OBS;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          result_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- rtl/cbf_datapath.sv -----
module cbf_datapath
  import cbf_pkg::*;
#(
  parameter int NUM_LABELS = DEF_NUM_LABELS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [ACTION_W-1:0]  action,
  input  logic [LABEL_W-1:0]   label,
  input  logic [SCORE_W-1:0]   score,
  input  logic [$clog2(NUM_LABELS)-1:0] slot,
  input  cbf_cmd_t             cmd,
  output cbf_stat_t            stat,
  output logic                 found,
  output logic [LABEL_W-1:0]   best_label,
  output logic [SCORE_W-1:0]   result_score,
  output logic [SCORE_W-1:0]   unknown_mass,
  output logic [STATUS_W-1:0]  status
);
  localparam int SW = $clog2(NUM_LABELS);
  localparam int CW = SW + 1;
  localparam int TW = SCORE_W + CW;            // total width
  localparam int NW = SCORE_W + FRAC_BITS;     // dividend width
  localparam int QW = NW;
  localparam int DCW = $clog2(NW + 1);
  localparam logic [NW-1:0] ONE = NW'(1) << FRAC_BITS;

  logic [SCORE_W-1:0] class_score [NUM_LABELS];
  logic [NUM_LABELS-1:0] class_valid;
  logic [SCORE_W-1:0] obs_score [NUM_LABELS];
  logic [NUM_LABELS-1:0] obs_valid;
  logic obs_bad;
  logic [ACTION_W-1:0] act;
  logic [SCORE_W-1:0] scr;
  logic [CW-1:0] n_cnt, m_cnt;
  logic [TW-1:0] total;
  logic [SCORE_W-1:0] share;
  logic share_mode;

  // shared restoring divider
  logic [NW-1:0] dvd;
  logic [TW-1:0] dvs;
  logic [TW:0] rem;
  logic [QW-1:0] quo;
  logic [DCW-1:0] dcnt;
  logic dbusy;
  logic [TW:0] trial;

  logic [SCORE_W-1:0] cur;
  logic [2*SCORE_W-1:0] prod;
  logic [2*SCORE_W-1:0] prod_sh;
  logic [SCORE_W-1:0] mul_b;
  logic [SCORE_W-1:0] prod_sat;
  logic [SCORE_W-1:0] quo_sat;

  assign cur = class_score[slot];
  assign mul_b = (cmd.op == OP_MUL_UNK) ? scr
               : (obs_valid[slot] ? obs_score[slot] : share);
  assign prod = (cmd.op == OP_MUL_UNK ? unknown_mass : cur) * mul_b;
  assign prod_sh = prod >> FRAC_BITS;
  assign prod_sat = (prod_sh > (2*SCORE_W)'(SCORE_MAX)) ? SCORE_MAX : prod_sh[SCORE_W-1:0];
  assign quo_sat = (quo > QW'(SCORE_MAX)) ? SCORE_MAX : quo[SCORE_W-1:0];
  assign trial = {rem[TW-1:0], dvd[NW-1]} - {1'b0, dvs};

  assign stat.action = act;
  assign stat.obs_bad = obs_bad;
  assign stat.obs_any = share_mode ? 1'b0 : (obs_valid != '0);
  assign stat.total_zero = (total == '0);
  assign stat.slot_valid = class_valid[slot];
  assign stat.div_done = !dbusy;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_valid <= '0;
      obs_valid <= '0;
      obs_bad <= 1'b0;
      unknown_mass <= '0;
      dbusy <= 1'b0;
      share_mode <= 1'b0;
      status <= ST_OK;
      found <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_LATCH: begin
          act <= action;
          scr <= score;
          status <= ST_OK;
          found <= 1'b0;
          best_label <= '0;
          result_score <= '0;
          share_mode <= 1'b0;
          if (action == ACT_SET && 32'(label) < NUM_LABELS) begin
            if (class_valid == '0 && unknown_mass == '0 && NW'(score) <= ONE)
              unknown_mass <= SCORE_W'(ONE - NW'(score));
            class_score[SW'(label)] <= score;
            class_valid[SW'(label)] <= 1'b1;
          end else if (action == ACT_SET_UNK) begin
            unknown_mass <= score;
          end else if (action == ACT_OBS && 32'(label) < NUM_LABELS) begin
            if (!class_valid[SW'(label)]) obs_bad <= 1'b1;
            obs_score[SW'(label)] <= score;
            obs_valid[SW'(label)] <= 1'b1;
          end else if (action == ACT_READ && 32'(label) < NUM_LABELS
                       && class_valid[SW'(label)]) begin
            found <= 1'b1;
            best_label <= label;
            result_score <= class_score[SW'(label)];
          end
        end
        OP_SCAN: begin
          if (cmd.first) begin
            n_cnt <= CW'(class_valid[slot]);
            m_cnt <= CW'(obs_valid[slot]);
            total <= TW'(unknown_mass) + (class_valid[slot] ? TW'(cur) : '0);
            if (act == ACT_MAX && class_valid[slot] && cur != '0) begin
              found <= 1'b1;
              best_label <= LABEL_W'(slot);
              result_score <= cur;
            end
          end else begin
            n_cnt <= n_cnt + CW'(class_valid[slot]);
            m_cnt <= m_cnt + CW'(obs_valid[slot]);
            total <= total + (class_valid[slot] ? TW'(cur) : '0);
            if (act == ACT_MAX && class_valid[slot] && cur > result_score) begin
              found <= 1'b1;
              best_label <= LABEL_W'(slot);
              result_score <= cur;
            end
          end
        end
        OP_SHARE_START: begin
          share_mode <= 1'b1;
          dvd <= NW'(scr) << FRAC_BITS;
          dvs <= TW'(n_cnt - m_cnt);
          rem <= '0;
          dcnt <= DCW'(NW);
          dbusy <= (n_cnt > m_cnt);
          quo <= '0;
        end
        OP_DIV_START: begin
          dvd <= NW'(cmd.div_unk ? unknown_mass : cur) << FRAC_BITS;
          dvs <= total;
          rem <= '0;
          quo <= '0;
          dcnt <= DCW'(NW);
          dbusy <= 1'b1;
        end
        OP_DIV_STEP: begin
          if (dbusy) begin
            dvd <= dvd << 1;
            if (!trial[TW]) begin
              rem <= trial;
              quo <= {quo[QW-2:0], 1'b1};
            end else begin
              rem <= {rem[TW-1:0], dvd[NW-1]};
              quo <= {quo[QW-2:0], 1'b0};
            end
            dcnt <= dcnt - 1'b1;
            if (dcnt == DCW'(1)) dbusy <= 1'b0;
          end
        end
        OP_DIV_WB: begin
          if (share_mode) begin
            // share = obs_unknown / (n - m); dividend was pre-shifted
            share <= (n_cnt > m_cnt) ? SCORE_W'(quo >> FRAC_BITS) : '0;
            share_mode <= 1'b0;
          end else if (cmd.div_unk) begin
            unknown_mass <= quo_sat;
          end else begin
            class_score[slot] <= quo_sat;
          end
        end
        OP_MUL: begin
          if (class_valid[slot]) class_score[slot] <= prod_sat;
        end
        OP_MUL_UNK: begin
          unknown_mass <= prod_sat;
        end
        OP_CLR_OBS: begin
          obs_valid <= '0;
          obs_bad <= 1'b0;
        end
        default: ;
      endcase
      if (cmd.set_status_bad) status <= ST_BAD_LABEL;
      if (cmd.set_status_zero) status <= ST_ZERO_TOTAL;
    end
  end
endmodule

// ----- rtl/categorical_bayes_fusion_top.sv -----
// Categorical score table with Bayesian fusion. One transaction in gives
// exactly one transaction out, and the next transaction is taken only after
// the result is loaded. Set, set-unknown, observation entry, read and the
// unused action act on the latched input alone. Maximum adds a scan of the
// slots, as do an empty or rejected observation end and a normalize with a
// zero total. Otherwise each division is a restoring division of
// FRAC_BITS+24 steps with its start and write-back, done once for the
// unknown mass and once per valid slot, and invalid slots are skipped.
// An observation end adds the share division (with no division steps when
// every valid slot was observed), a product pass and a second scan of the
// slots before the normalize. A single divider is shared by all divisions,
// so they run one after another. A stalled receiver holds the result; the
// next transaction is taken in but waits for the output before it
// completes, and the input stays blocked meanwhile.
module categorical_bayes_fusion_top
  import cbf_pkg::*;
#(
  parameter int NUM_LABELS = DEF_NUM_LABELS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // action[2:0], label[6:3], score[30:7], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // found[0], best_label[4:1], result_score[28:5],
                                // unknown_mass[52:29], status[54:53], zero
);
  `include "categorical_bayes_fusion_top_defines.svh"

  logic in_fire, busy, result_load, out_free;
  logic [$clog2(NUM_LABELS)-1:0] slot;
  cbf_cmd_t cmd;
  cbf_stat_t stat;
  logic found;
  logic [LABEL_W-1:0] best_label;
  logic [SCORE_W-1:0] result_score, unknown_mass;
  logic [STATUS_W-1:0] status;

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;
  // The output register may hold a result while the next item is taken in.
  assign out_free = !m_tvalid || m_tready;

  cbf_ctrl #(.NUM_LABELS(NUM_LABELS)) u_ctrl (
    .clk, .rst, .in_fire, .out_free, .busy, .result_load, .slot, .cmd, .stat
  );

  cbf_datapath #(.NUM_LABELS(NUM_LABELS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst,
    .action(s_tdata[2:0]), .label(s_tdata[6:3]), .score(s_tdata[30:7]),
    .slot, .cmd, .stat, .found, .best_label, .result_score, .unknown_mass, .status
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      m_tdata <= {1'b0, status, unknown_mass, result_score, best_label, found};
    end
  end

  `CBF_ASSERT_IMP(a_busy_no_accept, busy, !s_tready, "accepted while busy")
  `CBF_ASSERT_NEXT(a_load_valid, result_load, m_tvalid, "result not presented")
  `CBF_ASSERT_IMP(a_load_free, result_load, out_free, "result overwritten")
endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import cbf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NLAB = DEF_NUM_LABELS;
  localparam int FRAC = DEF_FRAC_BITS;
  localparam longint ONE = 64'd1 << FRAC;
  localparam logic [SCORE_W-1:0] ONE_SC = SCORE_W'(ONE);
  localparam longint LIMIT = 6_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SCORE_W-1:0]  unknown_mass;
    logic [SCORE_W-1:0]  result_score;
    logic [LABEL_W-1:0]  best_label;
    logic                found;
  } fusion_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  categorical_bayes_fusion_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow copy of the score table, kept in step with every accepted transaction.
  logic [SCORE_W-1:0] tbl_score [NLAB];
  logic               tbl_valid [NLAB];
  logic [SCORE_W-1:0] unk_mass;
  logic [SCORE_W-1:0] pend_score [NLAB];
  logic               pend_valid [NLAB];
  logic               pend_bad;

  fusion_result_t expected_q[$];
  int  mismatches = 0;
  bit  quiet_tail = 0;      // no idling in the last part of the run
  bit  hold_sink = 0;       // long receiver hold-off requested
  longint cycles = 0;

  initial forever #10 clk = ~clk;

  function automatic logic [SCORE_W-1:0] clamp24(longint unsigned v);
    return (v > SCORE_MAX) ? SCORE_MAX : v[SCORE_W-1:0];
  endfunction

  function automatic logic [SCORE_W-1:0] qmul(logic [SCORE_W-1:0] a, logic [SCORE_W-1:0] b);
    longint unsigned p;
    p = (longint'(a) * longint'(b)) >> FRAC;
    return clamp24(p);
  endfunction

  // Rescales the table so the scores plus unknown mass sum to one.
  function automatic logic [STATUS_W-1:0] rescale_table();
    longint unsigned total;
    total = unk_mass;
    for (int i = 0; i < NLAB; i++) if (tbl_valid[i]) total += tbl_score[i];
    if (total == 0) return ST_ZERO_TOTAL;
    unk_mass = clamp24((longint'(unk_mass) << FRAC) / total);
    for (int i = 0; i < NLAB; i++)
      if (tbl_valid[i]) tbl_score[i] = clamp24((longint'(tbl_score[i]) << FRAC) / total);
    return ST_OK;
  endfunction

  function automatic logic [STATUS_W-1:0] fuse_observation(logic [SCORE_W-1:0] obs_unk);
    int n, m;
    logic [SCORE_W-1:0] s;
    logic [STATUS_W-1:0] st;
    n = 0;
    m = 0;
    st = ST_OK;
    for (int i = 0; i < NLAB; i++) begin
      n += tbl_valid[i];
      m += pend_valid[i];
    end
    if (m != 0) begin
      if (pend_bad) begin
        st = ST_BAD_LABEL;
      end else begin
        for (int i = 0; i < NLAB; i++) begin
          if (!tbl_valid[i]) continue;
          if (pend_valid[i]) s = pend_score[i];
          else s = (n > m) ? SCORE_W'(obs_unk / (n - m)) : '0;
          tbl_score[i] = qmul(tbl_score[i], s);
        end
        unk_mass = qmul(unk_mass, obs_unk);
        st = rescale_table();
      end
    end
    for (int i = 0; i < NLAB; i++) pend_valid[i] = 0;
    pend_bad = 0;
    return st;
  endfunction

  function automatic fusion_result_t predict_fusion(logic [ACTION_W-1:0] act,
      logic [LABEL_W-1:0] lab, logic [SCORE_W-1:0] sc);
    fusion_result_t r;
    bit empty;
    logic [SCORE_W-1:0] bs;
    r = '0;
    case (act)
      ACT_SET: begin
        empty = 1;
        for (int i = 0; i < NLAB; i++) if (tbl_valid[i]) empty = 0;
        if (empty && unk_mass == 0 && sc <= ONE) unk_mass = clamp24(ONE - sc);
        tbl_score[lab] = sc;
        tbl_valid[lab] = 1;
      end
      ACT_SET_UNK: unk_mass = sc;
      ACT_OBS: begin
        if (!tbl_valid[lab]) pend_bad = 1;
        pend_score[lab] = sc;
        pend_valid[lab] = 1;
      end
      ACT_OBS_END: r.status = fuse_observation(sc);
      ACT_READ: begin
        if (tbl_valid[lab]) begin
          r.found = 1;
          r.best_label = lab;
          r.result_score = tbl_score[lab];
        end
      end
      ACT_MAX: begin
        bs = 0;
        for (int i = 0; i < NLAB; i++)
          if (tbl_valid[i] && tbl_score[i] > bs) begin
            bs = tbl_score[i];
            r.best_label = LABEL_W'(i);
          end
        if (bs != 0) begin
          r.found = 1;
          r.result_score = bs;
        end else begin
          r.best_label = 0;
        end
      end
      ACT_NORM: r.status = rescale_table();
      default: ;
    endcase
    r.unknown_mass = unk_mass;
    return r;
  endfunction

  // Sends one transaction, with an optional random gap first.
  task automatic send_item(logic [ACTION_W-1:0] act, logic [LABEL_W-1:0] lab,
      logic [SCORE_W-1:0] sc);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, sc, lab, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_q.push_back(predict_fusion(act, lab, sc));
  endtask

  // Stops offering transactions and waits until every result is back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [SCORE_W-1:0] rand_score();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SCORE_MAX;
      2: return ONE_SC;
      3: return SCORE_W'($urandom_range(0, 32'(ONE)));
      default: return SCORE_W'($urandom());
    endcase
  endfunction

  function automatic logic [LABEL_W-1:0] valid_label();
    int k;
    k = $urandom_range(0, NLAB - 1);
    for (int i = 0; i < NLAB; i++)
      if (tbl_valid[(k + i) % NLAB]) return LABEL_W'((k + i) % NLAB);
    return LABEL_W'(k);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        stall = 0;
        while (stall < 3000) begin
          @(posedge clk);
          stall++;
        end
        hold_sink = 0;
        m_tready <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compares each result transaction against the oldest prediction.
  initial begin
    fusion_result_t got, want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got = m_tdata[54:0];
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp found=%0d lab=%0d score=%h unk=%h st=%0d",
                        " | got found=%0d lab=%0d score=%h unk=%h st=%0d"},
                want.found, want.best_label, want.result_score, want.unknown_mass,
                want.status, got.found, got.best_label, got.result_score,
                got.unknown_mass, got.status);
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_basic_ops();
    send_item(ACT_MAX, 0, 0);            // empty table gives no maximum
    send_item(ACT_NORM, 0, 0);           // zero total
    send_item(ACT_READ, 4'hF, 0);        // read of an unset slot
    send_item(ACT_SET, 3, 24'h004000);   // first set fixes the unknown mass
    send_item(ACT_SET, 0, 0);
    send_item(ACT_SET, 4'hF, SCORE_MAX);
    send_item(ACT_READ, 4'hF, 0);
    send_item(ACT_MAX, 0, 0);
    send_item(ACT_SET, 7, SCORE_MAX);    // tie: the lower slot takes the maximum
    send_item(ACT_MAX, 0, 0);
    send_item(ACT_NORM, 0, 0);
    send_item(ACT_SET_UNK, 0, SCORE_MAX);
    send_item(ACT_SET_UNK, 0, 0);
    send_item(3'd7, 4'hA, SCORE_MAX);    // unused action
  endtask

  task automatic test_observations();
    send_item(ACT_OBS_END, 0, ONE_SC);   // empty observation
    send_item(ACT_OBS, 3, ONE_SC);
    send_item(ACT_OBS, 3, 24'h008000);   // repeated entry overwrites
    send_item(ACT_OBS, 0, SCORE_MAX);
    send_item(ACT_OBS_END, 0, SCORE_MAX);
    send_item(ACT_OBS, 9, ONE_SC);       // unset label flags the observation
    send_item(ACT_OBS, 3, ONE_SC);
    send_item(ACT_OBS_END, 0, ONE_SC);
    send_item(ACT_OBS, 7, 0);
    send_item(ACT_OBS_END, 0, 0);        // products all zero leave zero total
    send_item(ACT_READ, 7, 0);
  endtask

  // Mostly well-formed observations with random content, plus noise.
  task automatic test_random(int count);
    int sent, k;
    sent = 0;
    while (sent < count) begin
      if (count - sent < 120) quiet_tail = 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++) begin
            send_item(ACT_OBS,
                      ($urandom_range(0, 15) == 0) ? LABEL_W'($urandom()) : valid_label(),
                      rand_score());
            sent++;
          end
          send_item(ACT_OBS_END, LABEL_W'($urandom()), rand_score());
        end
        4: send_item(ACT_SET, LABEL_W'($urandom()), rand_score());
        5: send_item(ACT_READ, LABEL_W'($urandom()), SCORE_W'($urandom()));
        6: send_item(ACT_MAX, LABEL_W'($urandom()), SCORE_W'($urandom()));
        7: send_item(ACT_NORM, LABEL_W'($urandom()), SCORE_W'($urandom()));
        8: send_item(($urandom_range(0, 1) != 0) ? ACT_SET_UNK : 3'd7,
                     LABEL_W'($urandom()), rand_score());
        default: send_item(ACT_OBS_END, LABEL_W'($urandom()), rand_score());
      endcase
      sent++;
    end
  endtask

  task automatic test_backpressure();
    hold_sink = 1;
    for (int i = 0; i < 20; i++) send_item(ACT_READ, LABEL_W'($urandom()), 0);
    wait_drained();                      // sender pauses until all results are back
  endtask

  initial begin
    for (int i = 0; i < NLAB; i++) begin
      tbl_score[i] = '0;
      tbl_valid[i] = 0;
      pend_score[i] = '0;
      pend_valid[i] = 0;
    end
    unk_mass = '0;
    pend_bad = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_basic_ops();
    test_observations();
    test_backpressure();
    test_random(1100);
    wait_drained();
    repeat (1000) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
